// ----- rtl/sslew_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sslew_pkg
// Types and constants shared by the servo slew limiter: beat structs, pulse
// limits and the fixed-point reciprocal used for the PWM count scaling.
// ----------------------------------------------------------------------------
package sslew_pkg;

    localparam int PULSE_W = 12;
    localparam int INDEX_W = 5;
    localparam int LOCAL_W = 4;

    localparam logic [PULSE_W-1:0] PULSE_MIN       = 12'd500;
    localparam logic [PULSE_W-1:0] PULSE_MAX       = 12'd2700;
    localparam logic [PULSE_W-1:0] PULSE_MID       = 12'd1600;
    localparam logic [PULSE_W-1:0] STEP_DEFAULT    = 12'd50;
    localparam logic [PULSE_W-1:0] STEP_ZERO_SUBST = 12'd5;
    localparam logic [PULSE_W-1:0] COUNT_MAX       = 12'd4095;
    localparam logic [INDEX_W-1:0] CHANNELS_PER_CTRL = 5'd16;

    // pulse*4096/20000 == pulse*128/625, done as pulse*ceil(2^24*128/625) >> 24;
    // the rounding error stays below 1/625 for any 12-bit pulse, so it is exact
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 22'd3435974;
    localparam int PROD_W = PULSE_W + RECIP_W;

    typedef struct packed {
        logic [INDEX_W-1:0] chan_id;
        logic [PULSE_W-1:0] target_pulse;
        logic               tick_last;
    } servo_in_t;

    typedef struct packed {
        logic               controller_select;
        logic [LOCAL_W-1:0] local_channel;
        logic [PULSE_W-1:0] pulse_now;
        logic [PULSE_W-1:0] off_count;
        logic               all_reached;
    } servo_out_t;

    typedef struct packed {
        logic store_we;
        logic acc_next;
    } upd_status_t;

    function automatic logic [PULSE_W-1:0] clamp_pulse(input logic [PULSE_W-1:0] v);
        logic [PULSE_W-1:0] r;
        if (v < PULSE_MIN)
            r = PULSE_MIN;
        else if (v > PULSE_MAX)
            r = PULSE_MAX;
        else
            r = v;
        return r;
    endfunction

endpackage : sslew_pkg
`default_nettype wire

// ----- rtl/sslew_counts.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sslew_counts
// Converts a pulse width in microseconds to the PWM off count of a 50 Hz,
// 4096-step frame, saturated at the top count.
// ----------------------------------------------------------------------------
module sslew_counts (
    input  wire logic [sslew_pkg::PULSE_W-1:0] pulse,
    output logic      [sslew_pkg::PULSE_W-1:0] off_count
);
    import sslew_pkg::*;

    logic [PROD_W-1:0]  prod;
    logic [PULSE_W-1:0] quot;

    assign prod = PROD_W'(pulse) * PROD_W'(RECIP_MULT);
    assign quot = PULSE_W'(prod[PROD_W-1:RECIP_SHIFT]);

    always_comb
    begin
        if (quot > COUNT_MAX)
            off_count = COUNT_MAX;
        else
            off_count = quot;
    end

endmodule : sslew_counts
`default_nettype wire

// ----- rtl/sslew_pos_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sslew_pos_store
// Per-channel stored pulse widths: one combinational read port, one write
// port, every entry reset to mid travel.
// ----------------------------------------------------------------------------
module sslew_pos_store #(
    parameter int SERVO_CHANNELS = 24,
    parameter int IDX_W          = 5
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [IDX_W-1:0]                  rd_addr,
    output logic      [sslew_pkg::PULSE_W-1:0]     rd_data,
    input  wire logic                              wr_en,
    input  wire logic [IDX_W-1:0]                  wr_addr,
    input  wire logic [sslew_pkg::PULSE_W-1:0]     wr_data
);
    import sslew_pkg::*;

    logic [PULSE_W-1:0] pos_reg [SERVO_CHANNELS];

    assign rd_data = pos_reg[rd_addr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SERVO_CHANNELS; i++)
                pos_reg[i] <= PULSE_MID;
        end
        else if (wr_en)
        begin
            pos_reg[wr_addr] <= wr_data;
        end
    end

endmodule : sslew_pos_store
`default_nettype wire

// ----- rtl/sslew_update.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sslew_update
// One slew step for one beat: clamps target and position, moves the position
// toward the target by at most the step (an out-of-range channel reports the
// target, not stored), folds the tick-complete flag and builds the result beat.
// ----------------------------------------------------------------------------
module sslew_update #(
    parameter int SERVO_CHANNELS = 24
) (
    input  wire sslew_pkg::servo_in_t              item,
    input  wire logic [sslew_pkg::PULSE_W-1:0]     cur_pulse,
    input  wire logic [sslew_pkg::PULSE_W-1:0]     step_size,
    input  wire logic                              acc,
    output sslew_pkg::servo_out_t                  result,
    output logic      [sslew_pkg::PULSE_W-1:0]     new_pulse,
    output sslew_pkg::upd_status_t                 status
);
    import sslew_pkg::*;

    localparam logic [INDEX_W:0] CHAN_LIMIT = (INDEX_W+1)'(SERVO_CHANNELS);

    logic [PULSE_W-1:0] step_eff;
    logic [PULSE_W-1:0] tgt;
    logic [PULSE_W-1:0] cur;
    logic [PULSE_W-1:0] moved;
    logic [PULSE_W-1:0] now;
    logic               in_range;
    logic               reached;
    logic               acc_and;
    logic [PULSE_W-1:0] counts;

    assign step_eff = (step_size == '0) ? STEP_ZERO_SUBST : step_size;
    assign tgt      = clamp_pulse(item.target_pulse);
    assign cur      = clamp_pulse(cur_pulse);
    assign in_range = {1'b0, item.chan_id} < CHAN_LIMIT;

    // step never overshoots, so the result stays between cur and tgt
    always_comb
    begin
        if (cur < tgt)
            moved = (step_eff >= tgt - cur) ? tgt : cur + step_eff;
        else if (cur > tgt)
            moved = (step_eff >= cur - tgt) ? tgt : cur - step_eff;
        else
            moved = tgt;
    end

    assign now       = in_range ? moved : tgt;
    assign new_pulse = moved;
    assign reached   = !in_range || (moved == tgt);
    assign acc_and   = acc & reached;

    assign status.store_we = in_range;
    assign status.acc_next = item.tick_last ? 1'b1 : acc_and;

    sslew_counts u_counts (
        .pulse     (now),
        .off_count (counts)
    );

    assign result.controller_select = item.chan_id >= CHANNELS_PER_CTRL;
    assign result.local_channel     = item.chan_id[LOCAL_W-1:0];
    assign result.pulse_now         = now;
    assign result.off_count         = counts;
    assign result.all_reached       = item.tick_last & acc_and;

endmodule : sslew_update
`default_nettype wire

// ----- rtl/servo_slew_pwm_counts.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// servo_slew_pwm_counts
// Slew-rate limiter for a bank of servo channels with PWM count output.
// ----------------------------------------------------------------------------
// Each request beat names a servo channel and a target pulse in microseconds;
// the block clamps it to 500..2700 us, steps the stored position toward it by
// at most step_size (0 acts as 5), and returns the new pulse, its 50 Hz off
// count, the controller select and local channel. On a beat marked tick_last
// the response reports whether every servo of that tick reached its target.
// One beat is accepted per clock while responses are taken; an accepted beat
// is captured in the input register, then passes through the slew update into
// the result register, from which the response port presents it.
// The per-channel position is written back as the beat moves into the result
// register, so back-to-back beats to the same channel see each
// other's update. While responses are held off the block buffers two beats,
// then drops req_ready until the response beat is taken.
// Positions reset to 1600 us; step_size resets to 50.
module servo_slew_pwm_counts #(
    parameter int SERVO_CHANNELS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire sslew_pkg::servo_in_t          req_data,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output sslew_pkg::servo_out_t              rsp_data,
    input  wire logic                          cfg_wr_en,
    input  wire logic [sslew_pkg::PULSE_W-1:0] cfg_wr_data
);
    import sslew_pkg::*;

    localparam int IDX_W = (SERVO_CHANNELS > 1) ? $clog2(SERVO_CHANNELS) : 1;

    servo_in_t          req_reg;
    logic               req_vld_reg, req_vld_next;
    servo_out_t         rsp_reg;
    logic               rsp_vld_reg, rsp_vld_next;
    logic [PULSE_W-1:0] step_reg;
    logic               acc_reg, acc_next;

    logic               advance;
    logic               req_take;
    logic [IDX_W-1:0]   pos_addr;
    logic [PULSE_W-1:0] pos_rd;
    logic [PULSE_W-1:0] pos_new;
    servo_out_t         result;
    upd_status_t        status;

    assign advance   = req_vld_reg && (!rsp_vld_reg || rsp_ready);
    assign req_ready = !req_vld_reg || advance;
    assign req_take  = req_valid && req_ready;
    assign pos_addr  = req_reg.chan_id[IDX_W-1:0];

    sslew_pos_store #(
        .SERVO_CHANNELS (SERVO_CHANNELS),
        .IDX_W          (IDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (pos_addr),
        .rd_data (pos_rd),
        .wr_en   (advance && status.store_we),
        .wr_addr (pos_addr),
        .wr_data (pos_new)
    );

    sslew_update #(
        .SERVO_CHANNELS (SERVO_CHANNELS)
    ) u_update (
        .item      (req_reg),
        .cur_pulse (pos_rd),
        .step_size (step_reg),
        .acc       (acc_reg),
        .result    (result),
        .new_pulse (pos_new),
        .status    (status)
    );

    always_comb
    begin
        req_vld_next = req_vld_reg;
        if (req_take)
            req_vld_next = 1'b1;
        else if (advance)
            req_vld_next = 1'b0;

        rsp_vld_next = rsp_vld_reg;
        if (advance)
            rsp_vld_next = 1'b1;
        else if (rsp_ready)
            rsp_vld_next = 1'b0;

        acc_next = advance ? status.acc_next : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
            acc_reg     <= 1'b1;
            step_reg    <= STEP_DEFAULT;
        end
        else
        begin
            req_vld_reg <= req_vld_next;
            rsp_vld_reg <= rsp_vld_next;
            acc_reg     <= acc_next;
            if (cfg_wr_en)
                step_reg <= cfg_wr_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_take)
            req_reg <= req_data;
        if (advance)
            rsp_reg <= result;
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp_data  = rsp_reg;

endmodule : servo_slew_pwm_counts
`default_nettype wire

// ----- rtl/sslew_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sslew_checker
// Port-level checks for the servo slew limiter, bound to the top level.
// ----------------------------------------------------------------------------
module sslew_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire logic                          req_ready,
    input  wire logic                          rsp_valid,
    input  wire logic                          rsp_ready,
    input  wire sslew_pkg::servo_out_t         rsp_data
);
    import sslew_pkg::*;

    logic [31:0] cnt_lo;
    logic [31:0] cnt_hi;
    logic [31:0] pulse_scaled;

    assign cnt_lo       = 32'(rsp_data.off_count) * 32'd20000;
    assign cnt_hi       = (32'(rsp_data.off_count) + 32'd1) * 32'd20000;
    assign pulse_scaled = 32'(rsp_data.pulse_now) * 32'd4096;

    // stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response beat changed while stalled");

    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.pulse_now >= PULSE_MIN && rsp_data.pulse_now <= PULSE_MAX)
        else $error("pulse_now outside travel limits");

    a_count_scale: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> cnt_lo <= pulse_scaled && cnt_hi > pulse_scaled)
        else $error("off_count does not match pulse_now");

    // accepted beat reaches the output once the output stage frees up
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) ##1 (!rsp_valid || rsp_ready) |=> rsp_valid)
        else $error("accepted beat did not reach the output");

endmodule : sslew_checker

bind servo_slew_pwm_counts sslew_checker u_sslew_checker (.*);
`default_nettype wire
